// ----- rtl/pvps_pkg.sv -----
`default_nettype none
package pvps_pkg;

  localparam int FRAC_BITS = 8;

  localparam int VEL_W = 16;
  localparam int POS_W = 24;
  localparam int REG_W = 15;

  localparam int SQ_W  = 2 * VEL_W;
  localparam int NUM_W = VEL_W + REG_W - 1;

  localparam int ROOT_STAGES = VEL_W;
  localparam int DIV_STAGES  = VEL_W;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL_STEP = 2'd2;

  localparam logic [REG_W-1:0] REG_RESET = 15'd256;

  typedef struct packed {
    logic                    limited;
    logic signed [VEL_W-1:0] tx;
    logic signed [VEL_W-1:0] ty;
    logic                    fzx;
    logic                    fzy;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/pvps_in_if.sv -----
`default_nettype none
interface pvps_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pvps_pkg::VEL_W-1:0]    force_x;
  logic signed [pvps_pkg::VEL_W-1:0]    force_y;
  logic signed [pvps_pkg::VEL_W-1:0]    vel_x;
  logic signed [pvps_pkg::VEL_W-1:0]    vel_y;
  logic signed [pvps_pkg::POS_W-1:0]    pos_x;
  logic signed [pvps_pkg::POS_W-1:0]    pos_y;

  modport source (output valid, force_x, force_y, vel_x, vel_y, pos_x, pos_y, input ready);
  modport sink (input valid, force_x, force_y, vel_x, vel_y, pos_x, pos_y, output ready);
endinterface
`default_nettype wire

// ----- rtl/pvps_out_if.sv -----
`default_nettype none
interface pvps_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pvps_pkg::VEL_W-1:0]    new_vel_x;
  logic signed [pvps_pkg::VEL_W-1:0]    new_vel_y;
  logic signed [pvps_pkg::POS_W-1:0]    new_pos_x;
  logic signed [pvps_pkg::POS_W-1:0]    new_pos_y;

  modport source (output valid, new_vel_x, new_vel_y, new_pos_x, new_pos_y, input ready);
  modport sink (input valid, new_vel_x, new_vel_y, new_pos_x, new_pos_y, output ready);
endinterface
`default_nettype wire

// ----- rtl/pvps_push.sv -----
`default_nettype none
module pvps_push (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic        [pvps_pkg::REG_W-1:0]    accel_gain,
  input  wire logic        [pvps_pkg::REG_W-1:0]    decel_step,
  input  wire logic signed [pvps_pkg::VEL_W-1:0]    force_x,
  input  wire logic signed [pvps_pkg::VEL_W-1:0]    force_y,
  input  wire logic signed [pvps_pkg::VEL_W-1:0]    vel_x,
  input  wire logic signed [pvps_pkg::VEL_W-1:0]    vel_y,
  output logic signed      [pvps_pkg::VEL_W-1:0]    tx,
  output logic signed      [pvps_pkg::VEL_W-1:0]    ty
);

  localparam int PW = pvps_pkg::VEL_W + pvps_pkg::REG_W + 2;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (pvps_pkg::FRAC_BITS - 1);
  localparam logic signed [PW:0] SAT_HI = (PW+1)'(32767);
  localparam logic signed [PW:0] SAT_LO = -(PW+1)'(32768);

  logic signed [pvps_pkg::VEL_W-1:0] f [2];
  logic signed [pvps_pkg::VEL_W-1:0] v [2];
  logic signed [PW-1:0]              prod [2];
  logic signed [pvps_pkg::VEL_W-1:0] vel1 [2];
  logic signed [pvps_pkg::VEL_W-1:0] res [2];

  assign f[0] = force_x;
  assign f[1] = force_y;
  assign v[0] = vel_x;
  assign v[1] = vel_y;

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic                               opp;
    logic        [pvps_pkg::REG_W:0]    gain;
    logic signed [pvps_pkg::REG_W+1:0]  gain_s;
    logic signed [PW-1:0]               rnd;
    logic signed [PW:0]                 sum;

    always_comb begin
      opp = (f[a] > 0 && v[a] < 0) || (f[a] < 0 && v[a] > 0);
      gain = {1'b0, accel_gain} + (opp ? {1'b0, decel_step} : '0);
      gain_s = $signed({1'b0, gain});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        prod[a] <= f[a] * gain_s;
        vel1[a] <= v[a];
      end
    end

    // round half up back to the velocity scale, add the velocity, then saturate
    always_comb begin
      rnd = (prod[a] + HALF) >>> pvps_pkg::FRAC_BITS;
      sum = rnd + vel1[a];
      if (sum > SAT_HI) begin
        res[a] = 16'sh7fff;
      end else if (sum < SAT_LO) begin
        res[a] = 16'sh8000;
      end else begin
        res[a] = sum[pvps_pkg::VEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx <= res[0];
      ty <= res[1];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pvps_isqrt.sv -----
`default_nettype none
module pvps_isqrt (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [pvps_pkg::SQ_W-1:0]     value,
  output logic      [pvps_pkg::VEL_W-1:0]    root
);

  localparam int N = pvps_pkg::ROOT_STAGES;
  localparam int W = pvps_pkg::SQ_W;

  logic [W-1:0] rem [N+1];
  logic [W-1:0] acc [N+1];

  assign rem[0] = value;
  assign acc[0] = '0;

  // one result bit per stage, highest first
  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam logic [W-1:0] B = W'(1) << (2 * (N - 1 - s));
    logic [W-1:0] trial;
    logic [W-1:0] rem_next;
    logic [W-1:0] acc_next;

    always_comb begin
      trial = acc[s] + B;
      if (rem[s] >= trial) begin
        rem_next = rem[s] - trial;
        acc_next = (acc[s] >> 1) + B;
      end else begin
        rem_next = rem[s];
        acc_next = acc[s] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= rem_next;
        acc[s+1] <= acc_next;
      end
    end
  end

  assign root = acc[N][pvps_pkg::VEL_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/pvps_div.sv -----
`default_nettype none
module pvps_div (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [pvps_pkg::NUM_W-1:0]    num_x,
  input  wire logic [pvps_pkg::NUM_W-1:0]    num_y,
  input  wire logic [pvps_pkg::VEL_W-1:0]    den,
  output logic      [pvps_pkg::VEL_W-1:0]    quo_x,
  output logic      [pvps_pkg::VEL_W-1:0]    quo_y
);

  localparam int N = pvps_pkg::DIV_STAGES;
  localparam int W = pvps_pkg::SQ_W;

  logic [W-1:0]                   rem [2][N+1];
  logic [pvps_pkg::VEL_W-1:0]     q   [2][N+1];
  logic [pvps_pkg::VEL_W-1:0]     d   [N+1];

  assign rem[0][0] = W'(num_x);
  assign rem[1][0] = W'(num_y);
  assign q[0][0]   = '0;
  assign q[1][0]   = '0;
  assign d[0]      = den;

  // restoring division, one quotient bit per stage for both lanes
  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int K = N - 1 - s;
    logic [W-1:0] dsh;

    assign dsh = W'(d[s]) << K;

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic                         ge;
      logic [pvps_pkg::VEL_W-1:0]   q_next;

      always_comb begin
        ge = rem[l][s] >= dsh;
        q_next = q[l][s];
        q_next[K] = ge;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[l][s+1] <= ge ? rem[l][s] - dsh : rem[l][s];
          q[l][s+1]   <= q_next;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d[s+1] <= d[s];
      end
    end
  end

  assign quo_x = q[0][N];
  assign quo_y = q[1][N];

endmodule
`default_nettype wire

// ----- rtl/projectile_velocity_position_step.sv -----
// Velocity and position update for one object per transfer.
// item_in carries force, velocity and position; item_out returns the new
// velocity and position, exactly one result per input, in order.
// Configuration: cfg_we with cfg_index (0 max_speed, 1 accel_gain,
// 2 decel_step) and cfg_data; write only while no item is in flight.
// From the input transfer to the valid result an item passes these stages:
// two stages for force scaling and saturation, two for the squares and the
// limit compare, 16 for the square root (one root bit per stage), 16 for the
// rescaling divide (one quotient bit per stage), one for drag and position.
// Throughput is one item per cycle while the receiver does not stall; the whole pipeline is one shift line.
// When the receiver holds ready low with a result waiting, the pipeline
// freezes and item_in.ready drops; nothing is lost or repeated.
// Reset clears all stage valid bits and loads 256 (1.0) into every configuration register.
`default_nettype none
module projectile_velocity_position_step (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  pvps_in_if.sink                                      item_in,
  pvps_out_if.source                                   item_out,
  input  wire logic                                    cfg_we,
  input  wire logic [pvps_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [pvps_pkg::REG_W-1:0]              cfg_data
);

  localparam int ND  = pvps_pkg::ROOT_STAGES;
  localparam int NQ  = pvps_pkg::DIV_STAGES;
  localparam int NST = 4 + ND + NQ + 1;

  typedef struct packed {
    pvps_pkg::side_t               sb;
    logic [pvps_pkg::NUM_W-1:0]    nx;
    logic [pvps_pkg::NUM_W-1:0]    ny;
  } wait_t;

  logic [pvps_pkg::REG_W-1:0] max_speed;
  logic [pvps_pkg::REG_W-1:0] accel_gain;
  logic [pvps_pkg::REG_W-1:0] decel_step;

  logic           en;
  logic [NST-1:0] vld;

  assign en = !vld[NST-1] || item_out.ready;
  assign item_in.ready = en;
  assign item_out.valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed  <= pvps_pkg::REG_RESET;
      accel_gain <= pvps_pkg::REG_RESET;
      decel_step <= pvps_pkg::REG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pvps_pkg::REG_MAX_SPEED:  max_speed  <= cfg_data;
        pvps_pkg::REG_ACCEL_GAIN: accel_gain <= cfg_data;
        pvps_pkg::REG_DECEL_STEP: decel_step <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], item_in.valid};
    end
  end

  // stages 1 and 2: force scaling
  logic signed [pvps_pkg::VEL_W-1:0] tx2;
  logic signed [pvps_pkg::VEL_W-1:0] ty2;

  pvps_push u_push (
    .clk        (clk),
    .en         (en),
    .accel_gain (accel_gain),
    .decel_step (decel_step),
    .force_x    (item_in.force_x),
    .force_y    (item_in.force_y),
    .vel_x      (item_in.vel_x),
    .vel_y      (item_in.vel_y),
    .tx         (tx2),
    .ty         (ty2)
  );

  logic                              fzx1, fzy1, fzx2, fzy2;
  logic signed [pvps_pkg::POS_W-1:0] px1, py1, px2, py2;

  always_ff @(posedge clk) begin
    if (en) begin
      fzx1 <= item_in.force_x == '0;
      fzy1 <= item_in.force_y == '0;
      px1  <= item_in.pos_x;
      py1  <= item_in.pos_y;
      fzx2 <= fzx1;
      fzy2 <= fzy1;
      px2  <= px1;
      py2  <= py1;
    end
  end

  // stage 3: squares and limit numerators
  logic [pvps_pkg::VEL_W-1:0]        ax2, ay2;
  logic [pvps_pkg::SQ_W-2:0]         sqx3, sqy3;
  logic [2*pvps_pkg::REG_W-1:0]      lim3;
  logic [pvps_pkg::NUM_W-1:0]        nx3, ny3;
  logic signed [pvps_pkg::VEL_W-1:0] tx3, ty3;
  logic                              fzx3, fzy3;
  logic signed [pvps_pkg::POS_W-1:0] px3, py3;

  assign ax2 = tx2[pvps_pkg::VEL_W-1] ? pvps_pkg::VEL_W'(-tx2) : pvps_pkg::VEL_W'(tx2);
  assign ay2 = ty2[pvps_pkg::VEL_W-1] ? pvps_pkg::VEL_W'(-ty2) : pvps_pkg::VEL_W'(ty2);

  always_ff @(posedge clk) begin
    if (en) begin
      sqx3 <= (pvps_pkg::SQ_W-1)'(ax2 * ax2);
      sqy3 <= (pvps_pkg::SQ_W-1)'(ay2 * ay2);
      lim3 <= max_speed * max_speed;
      nx3  <= pvps_pkg::NUM_W'(ax2 * max_speed);
      ny3  <= pvps_pkg::NUM_W'(ay2 * max_speed);
      tx3  <= tx2;
      ty3  <= ty2;
      fzx3 <= fzx2;
      fzy3 <= fzy2;
      px3  <= px2;
      py3  <= py2;
    end
  end

  // stage 4: length squared and limit decision
  logic [pvps_pkg::SQ_W-1:0] sq4;
  wait_t                     w4;

  always_ff @(posedge clk) begin
    if (en) begin
      sq4           <= {1'b0, sqx3} + {1'b0, sqy3};
      w4.sb.limited <= ({1'b0, sqx3} + {1'b0, sqy3}) > pvps_pkg::SQ_W'(lim3);
      w4.sb.tx      <= tx3;
      w4.sb.ty      <= ty3;
      w4.sb.fzx     <= fzx3;
      w4.sb.fzy     <= fzy3;
      w4.sb.px      <= px3;
      w4.sb.py      <= py3;
      w4.nx         <= nx3;
      w4.ny         <= ny3;
    end
  end

  // square root, with the item's other fields waiting alongside
  logic [pvps_pkg::VEL_W-1:0] root;
  wait_t                      wl [ND+1];

  pvps_isqrt u_isqrt (
    .clk   (clk),
    .en    (en),
    .value (sq4),
    .root  (root)
  );

  assign wl[0] = w4;
  for (genvar i = 0; i < ND; i++) begin : g_wait_root
    always_ff @(posedge clk) begin
      if (en) begin
        wl[i+1] <= wl[i];
      end
    end
  end

  // rescaling divide
  logic [pvps_pkg::VEL_W-1:0] qx, qy;
  pvps_pkg::side_t            sl [NQ+1];

  pvps_div u_div (
    .clk   (clk),
    .en    (en),
    .num_x (wl[ND].nx),
    .num_y (wl[ND].ny),
    .den   (root),
    .quo_x (qx),
    .quo_y (qy)
  );

  assign sl[0] = wl[ND].sb;
  for (genvar i = 0; i < NQ; i++) begin : g_wait_div
    always_ff @(posedge clk) begin
      if (en) begin
        sl[i+1] <= sl[i];
      end
    end
  end

  // final stage: sign back, drag toward zero, position
  function automatic logic signed [pvps_pkg::VEL_W-1:0] apply_sign(
    input logic                       neg,
    input logic [pvps_pkg::VEL_W-1:0] mag
  );
    logic signed [pvps_pkg::VEL_W:0] m;
    m = $signed({1'b0, mag});
    if (neg) begin
      m = -m;
    end
    return m[pvps_pkg::VEL_W-1:0];
  endfunction

  function automatic logic signed [pvps_pkg::VEL_W-1:0] drag(
    input logic                              fz,
    input logic signed [pvps_pkg::VEL_W-1:0] v,
    input logic        [pvps_pkg::REG_W-1:0] dstep
  );
    logic signed [pvps_pkg::VEL_W:0] a;
    logic signed [pvps_pkg::VEL_W:0] ds;
    logic signed [pvps_pkg::VEL_W-1:0] r;
    ds = $signed({2'b00, dstep});
    r = v;
    if (fz) begin
      if (v > 0) begin
        a = v - ds;
        r = (a < 0) ? '0 : a[pvps_pkg::VEL_W-1:0];
      end else if (v < 0) begin
        a = v + ds;
        r = (a > 0) ? '0 : a[pvps_pkg::VEL_W-1:0];
      end else begin
        r = '0;
      end
    end
    return r;
  endfunction

  pvps_pkg::side_t                   sf;
  logic signed [pvps_pkg::VEL_W-1:0] lx, ly, vx, vy;

  assign sf = sl[NQ];

  always_comb begin
    lx = sf.limited ? apply_sign(sf.tx[pvps_pkg::VEL_W-1], qx) : sf.tx;
    ly = sf.limited ? apply_sign(sf.ty[pvps_pkg::VEL_W-1], qy) : sf.ty;
    vx = drag(sf.fzx, lx, decel_step);
    vy = drag(sf.fzy, ly, decel_step);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_out.new_vel_x <= vx;
      item_out.new_vel_y <= vy;
      item_out.new_pos_x <= sf.px + pvps_pkg::POS_W'(vx);
      item_out.new_pos_y <= sf.py + pvps_pkg::POS_W'(vy);
    end
  end

endmodule
`default_nettype wire

// ----- tb/pvps_tb_if.sv -----
`timescale 1ns / 1ps
package pvps_tb_pkg;

  typedef struct packed {
    logic signed [pvps_pkg::VEL_W-1:0] vx;
    logic signed [pvps_pkg::VEL_W-1:0] vy;
    logic signed [pvps_pkg::POS_W-1:0] px;
    logic signed [pvps_pkg::POS_W-1:0] py;
  } motion_t;

  typedef struct packed {
    logic signed [pvps_pkg::VEL_W-1:0] fx;
    logic signed [pvps_pkg::VEL_W-1:0] fy;
    logic signed [pvps_pkg::VEL_W-1:0] vx;
    logic signed [pvps_pkg::VEL_W-1:0] vy;
    logic signed [pvps_pkg::POS_W-1:0] px;
    logic signed [pvps_pkg::POS_W-1:0] py;
  } object_t;
endpackage

// ----- tb/projectile_velocity_position_step_tb.sv -----
`timescale 1ns / 1ps
module projectile_velocity_position_step_tb;

  localparam int LATENCY = 37;
  localparam int STALL_LIMIT = 2000;

  class motion_scoreboard;
    longint max_speed, accel_gain, decel_step;
    pvps_tb_pkg::motion_t pending[$];
    int errors, checked;

    function new();
      max_speed = pvps_pkg::REG_RESET;
      accel_gain = pvps_pkg::REG_RESET;
      decel_step = pvps_pkg::REG_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function longint round_scale(longint p);
      longint q;
      q = p + (64'sd1 <<< (pvps_pkg::FRAC_BITS - 1));
      return q >>> pvps_pkg::FRAC_BITS;
    endfunction

    function longint push_axis(longint f, longint v);
      longint g, t;
      g = accel_gain;
      if ((f > 0 && v < 0) || (f < 0 && v > 0)) g += decel_step;
      t = v + round_scale(f * g);
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return t;
    endfunction

    function longint drag_axis(longint f, longint v);
      if (f != 0) return v;
      if (v > 0) return (v - decel_step < 0) ? 0 : v - decel_step;
      if (v < 0) return (v + decel_step > 0) ? 0 : v + decel_step;
      return 0;
    endfunction

    function longint root_floor(longint s);
      longint r;
      r = 0;
      for (int b = 31; b >= 0; b--)
        if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= s) r += 64'sd1 << b;
      return r;
    endfunction

    function void note_object(pvps_tb_pkg::object_t o);
      longint tx, ty, sq, len;
      pvps_tb_pkg::motion_t m;
      tx = push_axis(o.fx, o.vx);
      ty = push_axis(o.fy, o.vy);
      sq = tx * tx + ty * ty;
      if (sq > max_speed * max_speed) begin
        len = root_floor(sq);
        if (len < 1) len = 1;
        tx = (tx * max_speed) / len;
        ty = (ty * max_speed) / len;
      end
      tx = drag_axis(o.fx, tx);
      ty = drag_axis(o.fy, ty);
      m.vx = tx[pvps_pkg::VEL_W-1:0];
      m.vy = ty[pvps_pkg::VEL_W-1:0];
      m.px = o.px + tx[pvps_pkg::POS_W-1:0];
      m.py = o.py + ty[pvps_pkg::POS_W-1:0];
      pending.push_back(m);
    endfunction

    function void check_motion(pvps_tb_pkg::motion_t a);
      pvps_tb_pkg::motion_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.vx !== e.vx) begin
        $display("%0t: new_vel_x expected %0d actual %0d", $time, e.vx, a.vx); errors++;
      end
      if (a.vy !== e.vy) begin
        $display("%0t: new_vel_y expected %0d actual %0d", $time, e.vy, a.vy); errors++;
      end
      if (a.px !== e.px) begin
        $display("%0t: new_pos_x expected %0d actual %0d", $time, e.px, a.px); errors++;
      end
      if (a.py !== e.py) begin
        $display("%0t: new_pos_y expected %0d actual %0d", $time, e.py, a.py); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [pvps_pkg::CFG_IDX_W-1:0] cfg_index = pvps_pkg::REG_MAX_SPEED;
  logic [pvps_pkg::REG_W-1:0] cfg_data = '0;
  pvps_in_if item_in();
  pvps_out_if item_out();

  projectile_velocity_position_step dut (
    .clk(clk), .rst(rst), .item_in(item_in), .item_out(item_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  motion_scoreboard board = new();
  int idle_cycles = 0;
  int sent = 0;
  int stall_mode = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    item_in.valid = 0;
    item_in.force_x = '0; item_in.force_y = '0;
    item_in.vel_x = '0; item_in.vel_y = '0;
    item_in.pos_x = '0; item_in.pos_y = '0;
    item_out.ready = 0;
  end

  // checks results, counts idle cycles for the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (item_out.valid && item_out.ready)
        board.check_motion({item_out.new_vel_x, item_out.new_vel_y,
                            item_out.new_pos_x, item_out.new_pos_y});
      if ((item_in.valid && item_in.ready) || (item_out.valid && item_out.ready) || cfg_we)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("projectile_velocity_position_step test failed");
        $finish;
      end
    end
  end

  // receiver stall pattern, changed at the falling edge
  always @(negedge clk) begin
    case (stall_mode)
      0: item_out.ready <= 1'b1;
      1: item_out.ready <= ($urandom_range(0, 3) != 0);
      default: item_out.ready <= ($urandom_range(0, 3) == 0);
    endcase
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
  end

  task automatic write_reg(logic [pvps_pkg::CFG_IDX_W-1:0] idx,
                           logic [pvps_pkg::REG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      pvps_pkg::REG_MAX_SPEED: board.max_speed = val;
      pvps_pkg::REG_ACCEL_GAIN: board.accel_gain = val;
      pvps_pkg::REG_DECEL_STEP: board.decel_step = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // valid stays high through a burst; only dropped for a gap
  task automatic send_object(pvps_tb_pkg::object_t o, bit gap_after);
    item_in.valid <= 1'b1;
    item_in.force_x <= o.fx; item_in.force_y <= o.fy;
    item_in.vel_x <= o.vx; item_in.vel_y <= o.vy;
    item_in.pos_x <= o.px; item_in.pos_y <= o.py;
    do @(posedge clk); while (!item_in.ready);
    board.note_object(o);
    sent++;
    @(negedge clk);
    if (gap_after) begin
      item_in.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  function automatic logic signed [pvps_pkg::VEL_W-1:0] rand_vel(int kind);
    case (kind)
      0: return pvps_pkg::VEL_W'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return '0;
      default: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
    endcase
  endfunction

  function automatic pvps_tb_pkg::object_t rand_object();
    pvps_tb_pkg::object_t o;
    o.fx = rand_vel($urandom_range(0, 5) == 0 ? 2 : $urandom_range(0, 3));
    o.fy = rand_vel($urandom_range(0, 5) == 0 ? 2 : $urandom_range(0, 3));
    o.vx = rand_vel($urandom_range(0, 3));
    o.vy = rand_vel($urandom_range(0, 3));
    o.px = pvps_pkg::POS_W'($urandom);
    o.py = pvps_pkg::POS_W'($urandom);
    return o;
  endfunction

  task automatic random_phase(int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) burst = $urandom_range(1, 20);
      burst--;
      send_object(rand_object(), burst == 0 && $urandom_range(0, 2) != 0);
    end
    item_in.valid <= 1'b0;
  endtask

  initial begin
    pvps_tb_pkg::object_t o;
    logic signed [pvps_pkg::VEL_W-1:0] edges[5];
    edges = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd1, -16'sd1};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, zero force drag, opposing force, position wrap
    for (int i = 0; i < 20; i++) begin
      o.fx = edges[i % 5]; o.fy = edges[(i / 5) % 5];
      o.vx = edges[(i + 2) % 5]; o.vy = edges[(i + 3) % 5];
      o.px = (i % 2) ? 24'sh7fffff : 24'sh800000;
      o.py = (i % 3) ? 24'sh800000 : 24'sh7fffff;
      send_object(o, i % 4 == 3);
    end
    item_in.valid <= 1'b0;
    drain();

    // zero max speed limits every vector to zero
    write_reg(pvps_pkg::REG_MAX_SPEED, '0);
    write_reg(pvps_pkg::REG_DECEL_STEP, '0);
    random_phase(80);
    drain();
    write_reg(pvps_pkg::REG_MAX_SPEED, 15'h7fff);
    write_reg(pvps_pkg::REG_ACCEL_GAIN, 15'h7fff);
    write_reg(pvps_pkg::REG_DECEL_STEP, 15'h7fff);
    random_phase(150);
    drain();
    write_reg(pvps_pkg::REG_ACCEL_GAIN, '0);
    write_reg(pvps_pkg::REG_MAX_SPEED, 15'd100);
    write_reg(pvps_pkg::REG_DECEL_STEP, 15'd3);
    random_phase(120);
    drain();
    for (int p = 0; p < 6; p++) begin
      write_reg(pvps_pkg::REG_MAX_SPEED, pvps_pkg::REG_W'($urandom_range(0, 32767)));
      write_reg(pvps_pkg::REG_ACCEL_GAIN, pvps_pkg::REG_W'($urandom_range(0, 32767)));
      write_reg(pvps_pkg::REG_DECEL_STEP, pvps_pkg::REG_W'($urandom_range(0, 600)));
      random_phase(100);
      drain();
    end

    $display("sent %0d objects over ten register settings, %0d results checked",
             sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("projectile_velocity_position_step test passed");
    else
      $display("projectile_velocity_position_step test failed");
    $finish;
  end
endmodule
